[src/obb_pkg.sv]
`default_nettype none
package obb_pkg;
    localparam int FRAC_BITS  = 8;
    localparam int COORD_BITS = 16;
    localparam int IN_W       = 48;
    localparam int EPS_W      = 8;
    localparam int NUM_AXES   = 15;
    localparam int AXIS_W     = 4;
    localparam logic [AXIS_W-1:0] AXIS_NONE = 4'd15;

    // signed widths of intermediate terms
    localparam int CEN_W = 2 * COORD_BITS + 3;      // center and offset t
    localparam int ROT_W = 2 * COORD_BITS + 2;      // R[i][j]
    localparam int AR_W  = ROT_W + 1;               // |R| + eps, signed
    localparam int TP_W  = CEN_W + COORD_BITS + 3;  // t in A frame
    localparam int SUM_W = 128;                     // exact compare width

    // tp is split in two halves so each product stays near 32x32
    localparam int TP_LO_W = TP_W / 2;              // unsigned low half
    localparam int TP_HI_W = TP_W - TP_LO_W;        // signed high half
    localparam int PHI_W   = TP_HI_W + ROT_W;       // high half * R
    localparam int PLO_W   = TP_LO_W + 1 + ROT_W;   // low half * R
    localparam int PROD_W  = TP_W + ROT_W;          // full tp * R
    localparam int HAR_W   = COORD_BITS + AR_W;     // half width * AR

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // unpack one signed value: x low, then y, then z
    function automatic t_coord get_coord(input logic [IN_W-1:0] w, input int k);
        get_coord = t_coord'(w[k*COORD_BITS +: COORD_BITS]);
    endfunction
endpackage
`default_nettype wire

[src/obb_geom.sv]
`default_nettype none
// Stages 1-2: world centers, relative rotation, offset, offset in A frame.
module obb_geom import obb_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [IN_W-1:0]              i_in [12],
    input  wire logic [EPS_W-1:0]             i_eps,
    output logic                              o_valid,
    output logic signed [TP_W-1:0]            o_tp [3],
    output logic signed [ROT_W-1:0]           o_rot [3][3],
    output logic signed [AR_W-1:0]            o_ar [3][3],
    output logic signed [COORD_BITS-1:0]      o_ha [3],
    output logic signed [COORD_BITS-1:0]      o_hb [3]
);
    t_coord ua [3][3];
    t_coord ub [3][3];
    logic signed [CEN_W-1:0] n_t [3];
    logic signed [CEN_W-1:0] r_t [3];
    t_coord r_ua [3][3];
    logic signed [ROT_W-1:0] n_rot [3][3];
    logic signed [AR_W-1:0]  n_ar [3][3];
    logic signed [ROT_W-1:0] r_rot [3][3];
    logic signed [AR_W-1:0]  r_ar [3][3];
    t_coord r_ha [3];
    t_coord r_hb [3];
    t_coord r_ha2 [3];
    t_coord r_hb2 [3];
    logic r_v1;
    logic r_v2;
    logic signed [TP_W-1:0] n_tp [3];
    logic signed [TP_W-1:0] r_tp [3];

    // stage 1: centers and rotation
    always_comb begin
        logic signed [CEN_W-1:0] ca;
        logic signed [CEN_W-1:0] cb;
        logic signed [ROT_W-1:0] s;
        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
                ua[i][c] = get_coord(i_in[i], c);
                ub[i][c] = get_coord(i_in[6+i], c);
            end
        end
        for (int c = 0; c < 3; c++) begin
            ca = CEN_W'(get_coord(i_in[3], c)) <<< FRAC_BITS;
            cb = CEN_W'(get_coord(i_in[9], c)) <<< FRAC_BITS;
            for (int k = 0; k < 3; k++) begin
                ca = ca + CEN_W'(ua[k][c] * get_coord(i_in[4], k));
                cb = cb + CEN_W'(ub[k][c] * get_coord(i_in[10], k));
            end
            n_t[c] = cb - ca;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s = '0;
                for (int c = 0; c < 3; c++) s = s + ROT_W'(ua[i][c] * ub[j][c]);
                n_rot[i][j] = s;
                n_ar[i][j] = (s < 0 ? -AR_W'(s) : AR_W'(s))
                           + AR_W'({i_eps, {FRAC_BITS{1'b0}}});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_t <= n_t;
            r_ua <= ua;
            r_rot <= n_rot;
            r_ar <= n_ar;
            for (int c = 0; c < 3; c++) begin
                r_ha[c] <= get_coord(i_in[5], c);
                r_hb[c] <= get_coord(i_in[11], c);
            end
        end
    end

    // stage 2: offset projected on A axes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_tp[i] = '0;
            for (int c = 0; c < 3; c++) n_tp[i] = n_tp[i] + TP_W'(r_t[c] * r_ua[i][c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_tp <= n_tp;
            o_rot <= r_rot;
            o_ar <= r_ar;
            r_ha2 <= r_ha;
            r_hb2 <= r_hb;
        end
    end

    assign o_valid = r_v2;
    assign o_tp = r_tp;
    assign o_ha = r_ha2;
    assign o_hb = r_hb2;
endmodule
`default_nettype wire

[src/obb_axes.sv]
`default_nettype none
// Stages 3-5: split products, full products and radii, then per-axis compares.
module obb_axes import obb_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic signed [TP_W-1:0]       i_tp [3],
    input  wire logic signed [ROT_W-1:0]      i_rot [3][3],
    input  wire logic signed [AR_W-1:0]       i_ar [3][3],
    input  wire logic signed [COORD_BITS-1:0] i_ha [3],
    input  wire logic signed [COORD_BITS-1:0] i_hb [3],
    output logic                              o_valid,
    output logic                              o_sep,
    output logic [AXIS_W-1:0]                 o_axis
);
    // stage 3 registers
    logic signed [PHI_W-1:0] r_phi [3][3][3];  // tp[a] high half * R[b][j]
    logic signed [PLO_W-1:0] r_plo [3][3][3];  // tp[a] low half * R[b][j]
    logic signed [HAR_W-1:0] r_hax [3][3][3];  // ha[p] * AR[q][j]
    logic signed [HAR_W-1:0] r_hbx [3][3][3];  // hb[p] * AR[i][q]
    logic signed [TP_W-1:0]  r_tp3 [3];
    t_coord r_ha3 [3];
    t_coord r_hb3 [3];
    logic r_v3;
    // stage 4 registers
    logic signed [PROD_W-1:0] n_prod [3][3][3];
    logic signed [PROD_W-1:0] r_prod [3][3][3]; // tp[a] * R[b][j]
    logic signed [SUM_W-1:0]  n_rhs [NUM_AXES];
    logic signed [SUM_W-1:0]  r_rhs [NUM_AXES];
    logic signed [TP_W-1:0]   r_tp4 [3];
    logic r_v4;
    // stage 5 registers
    logic [NUM_AXES-1:0] n_hit;
    logic [NUM_AXES-1:0] r_hit;
    logic r_v5;

    function automatic logic signed [SUM_W-1:0] wabs(input logic signed [SUM_W-1:0] v);
        wabs = v < 0 ? -v : v;
    endfunction

    // stage 3: half-width products of tp with every R entry, radius products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
        end
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r_tp3[a] <= i_tp[a];
                r_ha3[a] <= i_ha[a];
                r_hb3[a] <= i_hb[a];
                for (int b = 0; b < 3; b++) begin
                    for (int j = 0; j < 3; j++) begin
                        r_phi[a][b][j] <= PHI_W'($signed(i_tp[a][TP_W-1:TP_LO_W]))
                                        * PHI_W'(i_rot[b][j]);
                        r_plo[a][b][j] <= PLO_W'($signed({1'b0, i_tp[a][TP_LO_W-1:0]}))
                                        * PLO_W'(i_rot[b][j]);
                        r_hax[a][b][j] <= HAR_W'(i_ha[a]) * HAR_W'(i_ar[b][j]);
                        r_hbx[a][b][j] <= HAR_W'(i_hb[a]) * HAR_W'(i_ar[b][j]);
                    end
                end
            end
        end
    end

    // stage 4: join halves, sum radii for all 15 axes
    always_comb begin
        logic signed [SUM_W-1:0] ra;
        logic signed [SUM_W-1:0] rb;
        int i1, i2, j1, j2;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                for (int j = 0; j < 3; j++)
                    n_prod[a][b][j] = (PROD_W'(r_phi[a][b][j]) <<< TP_LO_W)
                                    + PROD_W'(r_plo[a][b][j]);
        // A face axes: ha[i] + sum hb[j]*AR[i][j]
        for (int i = 0; i < 3; i++) begin
            ra = SUM_W'(r_ha3[i]) <<< (2 * FRAC_BITS);
            for (int j = 0; j < 3; j++) ra = ra + SUM_W'(r_hbx[j][i][j]);
            n_rhs[i] = ra;
        end
        // B face axes: sum ha[k]*AR[k][i] + hb[i]
        for (int i = 0; i < 3; i++) begin
            ra = SUM_W'(r_hax[0][0][i]) + SUM_W'(r_hax[1][1][i]) + SUM_W'(r_hax[2][2][i]);
            n_rhs[3+i] = (ra <<< (2 * FRAC_BITS)) + (SUM_W'(r_hb3[i]) <<< (4 * FRAC_BITS));
        end
        // cross axes Ai x Bj
        for (int i = 0; i < 3; i++) begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++) begin
                j1 = (j + 1) % 3;
                j2 = (j + 2) % 3;
                ra = SUM_W'(r_hax[i1][i2][j]) + SUM_W'(r_hax[i2][i1][j]);
                rb = SUM_W'(r_hbx[j1][i][j2]) + SUM_W'(r_hbx[j2][i][j1]);
                n_rhs[6+3*i+j] = (ra + rb) <<< (2 * FRAC_BITS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
        if (i_en) begin
            r_prod <= n_prod;
            r_rhs <= n_rhs;
            r_tp4 <= r_tp3;
        end
    end

    // stage 5: projected offsets and strict compares
    always_comb begin
        logic signed [SUM_W-1:0] lhs;
        int i1, i2;
        for (int i = 0; i < 3; i++) begin
            n_hit[i] = wabs(SUM_W'(r_tp4[i])) > r_rhs[i];
        end
        for (int i = 0; i < 3; i++) begin
            lhs = SUM_W'(r_prod[0][0][i]) + SUM_W'(r_prod[1][1][i])
                + SUM_W'(r_prod[2][2][i]);
            n_hit[3+i] = wabs(lhs) > r_rhs[3+i];
        end
        for (int i = 0; i < 3; i++) begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++) begin
                lhs = SUM_W'(r_prod[i2][i1][j]) - SUM_W'(r_prod[i1][i2][j]);
                n_hit[6+3*i+j] = wabs(lhs) > r_rhs[6+3*i+j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v5 <= r_v4;
        end
        if (i_en) r_hit <= n_hit;
    end

    // first set bit in test order
    always_comb begin
        o_axis = AXIS_NONE;
        for (int k = NUM_AXES - 1; k >= 0; k--) begin
            if (r_hit[k]) o_axis = AXIS_W'(k);
        end
    end
    assign o_sep = |r_hit;
    assign o_valid = r_v5;
endmodule
`default_nettype wire

[src/obb_separating_axis_test.sv]
`default_nettype none
// OBB-OBB separating axis test. One box pair request is accepted per clock while
// the pipe is not held; its result passes through five pipeline stages (centers
// and rotation, offset in A's frame, split products, full products and radii,
// per-axis compares) and then the output register. The depth
// comes from keeping every multiplier near 32 by 32 bits. The whole pipe holds
// while a result waits untaken, so o_ready follows i_ready when o_valid is high.
// o_separating_axis is the first separating axis 0..14 (A axes, B axes, then
// cross axes Ai x Bj, i outer), or 15 with o_separated low. Epsilon resets to 1
// (1/256 in Q0.8); write it only while no request is in flight.
module obb_separating_axis_test import obb_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [EPS_W-1:0]  i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [IN_W-1:0]   i_a_axis0,
    input  wire logic [IN_W-1:0]   i_a_axis1,
    input  wire logic [IN_W-1:0]   i_a_axis2,
    input  wire logic [IN_W-1:0]   i_a_translation,
    input  wire logic [IN_W-1:0]   i_a_center_local,
    input  wire logic [IN_W-1:0]   i_a_half_width,
    input  wire logic [IN_W-1:0]   i_b_axis0,
    input  wire logic [IN_W-1:0]   i_b_axis1,
    input  wire logic [IN_W-1:0]   i_b_axis2,
    input  wire logic [IN_W-1:0]   i_b_translation,
    input  wire logic [IN_W-1:0]   i_b_center_local,
    input  wire logic [IN_W-1:0]   i_b_half_width,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_separated,
    output logic [AXIS_W-1:0]      o_separating_axis
);
    logic [EPS_W-1:0] r_eps;
    logic [IN_W-1:0] w_in [12];
    logic en;
    logic g_valid;
    logic signed [TP_W-1:0] g_tp [3];
    logic signed [ROT_W-1:0] g_rot [3][3];
    logic signed [AR_W-1:0] g_ar [3][3];
    t_coord g_ha [3];
    t_coord g_hb [3];
    logic x_valid;
    logic x_sep;
    logic [AXIS_W-1:0] x_axis;
    logic r_ov;
    logic r_sep;
    logic [AXIS_W-1:0] r_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_eps <= EPS_W'(1);
        else if (i_cfg_we) r_eps <= i_cfg_data;
    end

    assign w_in = '{i_a_axis0, i_a_axis1, i_a_axis2, i_a_translation, i_a_center_local,
                    i_a_half_width, i_b_axis0, i_b_axis1, i_b_axis2, i_b_translation,
                    i_b_center_local, i_b_half_width};

    // pipe advances when the output slot frees
    assign en = !r_ov || i_ready;
    assign o_ready = en;

    obb_geom u_geom (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_in(w_in), .i_eps(r_eps), .o_valid(g_valid), .o_tp(g_tp),
        .o_rot(g_rot), .o_ar(g_ar), .o_ha(g_ha), .o_hb(g_hb)
    );

    obb_axes u_axes (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(g_valid),
        .i_tp(g_tp), .i_rot(g_rot), .i_ar(g_ar), .i_ha(g_ha), .i_hb(g_hb),
        .o_valid(x_valid), .o_sep(x_sep), .o_axis(x_axis)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= x_valid;
        end
        if (en) begin
            r_sep <= x_sep;
            r_axis <= x_axis;
        end
    end

    assign o_valid = r_ov;
    assign o_separated = r_sep;
    assign o_separating_axis = r_axis;

    a_sep_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_separated == (o_separating_axis != AXIS_NONE)))
        else $error("separated flag disagrees with axis");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_separating_axis))
        else $error("stalled result changed");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("empty output but not ready");
endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import obb_pkg::*;

    typedef struct packed {
        logic [IN_W-1:0] a_axis0, a_axis1, a_axis2, a_translation, a_center_local, a_half_width;
        logic [IN_W-1:0] b_axis0, b_axis1, b_axis2, b_translation, b_center_local, b_half_width;
    } t_box_pair;

    typedef struct packed {
        logic              separated;
        logic [AXIS_W-1:0] axis;
    } t_sat_result;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [EPS_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid, o_separated;
    logic [AXIS_W-1:0] o_separating_axis;
    t_box_pair pair_q = '0;

    t_box_pair   pending_pairs[$];
    t_sat_result expected_hits[$];
    logic [EPS_W-1:0] eps_model = 8'd1;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;

    obb_separating_axis_test u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_a_axis0(pair_q.a_axis0), .i_a_axis1(pair_q.a_axis1),
        .i_a_axis2(pair_q.a_axis2), .i_a_translation(pair_q.a_translation),
        .i_a_center_local(pair_q.a_center_local), .i_a_half_width(pair_q.a_half_width),
        .i_b_axis0(pair_q.b_axis0), .i_b_axis1(pair_q.b_axis1),
        .i_b_axis2(pair_q.b_axis2), .i_b_translation(pair_q.b_translation),
        .i_b_center_local(pair_q.b_center_local), .i_b_half_width(pair_q.b_half_width),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_separated(o_separated), .o_separating_axis(o_separating_axis)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic signed [SUM_W-1:0] cv(input logic [IN_W-1:0] w, input int k);
        logic signed [COORD_BITS-1:0] v;
        v = w[k*COORD_BITS +: COORD_BITS];
        return SUM_W'(v);
    endfunction

    function automatic logic signed [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] v);
        return v < 0 ? -v : v;
    endfunction

    // exact 128-bit separating axis evaluation
    function automatic t_sat_result sat_predict(input t_box_pair p, input logic [EPS_W-1:0] eps);
        logic signed [SUM_W-1:0] ua[3][3], ub[3][3], ha[3], hb[3], t[3], tp[3];
        logic signed [SUM_W-1:0] rot[3][3], arot[3][3];
        logic signed [SUM_W-1:0] ca, cb, lhs, rhs, ra, rb, epsw;
        logic [IN_W-1:0] aw[3], bw[3];
        int axis, i1, i2, j1, j2;
        t_sat_result r;
        aw = '{p.a_axis0, p.a_axis1, p.a_axis2};
        bw = '{p.b_axis0, p.b_axis1, p.b_axis2};
        axis = AXIS_NONE;
        epsw = SUM_W'(eps) <<< FRAC_BITS;
        for (int i = 0; i < 3; i++)
            for (int c = 0; c < 3; c++) begin
                ua[i][c] = cv(aw[i], c);
                ub[i][c] = cv(bw[i], c);
            end
        for (int c = 0; c < 3; c++) begin
            ca = cv(p.a_translation, c) <<< FRAC_BITS;
            cb = cv(p.b_translation, c) <<< FRAC_BITS;
            for (int k = 0; k < 3; k++) begin
                ca += ua[k][c] * cv(p.a_center_local, k);
                cb += ub[k][c] * cv(p.b_center_local, k);
            end
            t[c] = cb - ca;
            ha[c] = cv(p.a_half_width, c);
            hb[c] = cv(p.b_half_width, c);
        end
        for (int i = 0; i < 3; i++) begin
            tp[i] = 0;
            for (int c = 0; c < 3; c++) tp[i] += t[c] * ua[i][c];
            for (int j = 0; j < 3; j++) begin
                rot[i][j] = 0;
                for (int c = 0; c < 3; c++) rot[i][j] += ua[i][c] * ub[j][c];
                arot[i][j] = mag(rot[i][j]) + epsw;
            end
        end
        // box A face axes
        for (int i = 0; i < 3; i++) if (axis == AXIS_NONE) begin
            rhs = ha[i] <<< (2 * FRAC_BITS);
            for (int j = 0; j < 3; j++) rhs += hb[j] * arot[i][j];
            if (mag(tp[i]) > rhs) axis = i;
        end
        // box B face axes
        for (int i = 0; i < 3; i++) if (axis == AXIS_NONE) begin
            lhs = 0;
            ra = 0;
            for (int k = 0; k < 3; k++) begin
                lhs += tp[k] * rot[k][i];
                ra += ha[k] * arot[k][i];
            end
            rhs = (ra <<< (2 * FRAC_BITS)) + (hb[i] <<< (4 * FRAC_BITS));
            if (mag(lhs) > rhs) axis = 3 + i;
        end
        // edge cross products
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) if (axis == AXIS_NONE) begin
                i1 = (i + 1) % 3; i2 = (i + 2) % 3;
                j1 = (j + 1) % 3; j2 = (j + 2) % 3;
                lhs = tp[i2] * rot[i1][j] - tp[i1] * rot[i2][j];
                ra = ha[i1] * arot[i2][j] + ha[i2] * arot[i1][j];
                rb = hb[j1] * arot[i][j2] + hb[j2] * arot[i][j1];
                if (mag(lhs) > ((ra + rb) <<< (2 * FRAC_BITS))) axis = 6 + 3 * i + j;
            end
        r.separated = (axis != AXIS_NONE);
        r.axis = AXIS_W'(axis);
        return r;
    endfunction

    function automatic logic [IN_W-1:0] vec3(input int x, input int y, input int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic logic [IN_W-1:0] rand_word();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    function automatic logic [IN_W-1:0] small_vec(input int span);
        return vec3($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                    $urandom_range(2 * span) - span);
    endfunction

    // two boxes with unit-ish axes and nearby centers: mix of hits and misses
    function automatic t_box_pair plausible_pair();
        t_box_pair p;
        int perm;
        logic [IN_W-1:0] ax[3];
        ax = '{vec3(256, 0, 0), vec3(0, 256, 0), vec3(0, 0, 256)};
        p.a_axis0 = ax[0] ^ small_vec(40); p.a_axis1 = ax[1] ^ small_vec(40);
        p.a_axis2 = ax[2] ^ small_vec(40);
        perm = $urandom_range(2);
        p.b_axis0 = ax[perm] + small_vec(60);
        p.b_axis1 = ax[(perm + 1) % 3] + small_vec(60);
        p.b_axis2 = ax[(perm + 2) % 3] + small_vec(60);
        p.a_translation = small_vec(1200); p.b_translation = small_vec(1200);
        p.a_center_local = small_vec(200); p.b_center_local = small_vec(200);
        p.a_half_width = vec3($urandom_range(600), $urandom_range(600), $urandom_range(600));
        p.b_half_width = vec3($urandom_range(600), $urandom_range(600), $urandom_range(600));
        if ($urandom_range(15) == 0) p.a_half_width = small_vec(300);
        return p;
    endfunction

    function automatic t_box_pair noise_pair();
        return {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
    endfunction

    // driver: valid held until accepted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready) begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    pair_q  <= pending_pairs.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // input monitor: predict on acceptance; output monitor: compare
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) expected_hits.push_back(sat_predict(pair_q, eps_model));
            if (o_valid && i_ready) begin
                if (expected_hits.size() == 0) begin
                    $error("unexpected result sep=%0d axis=%0d", o_separated, o_separating_axis);
                    errors++;
                end else begin
                    t_sat_result e;
                    e = expected_hits.pop_front();
                    if (o_separated !== e.separated) begin
                        $error("separated: expected %0d actual %0d", e.separated, o_separated);
                        errors++;
                    end
                    if (o_separating_axis !== e.axis) begin
                        $error("separating_axis: expected %0d actual %0d", e.axis,
                               o_separating_axis);
                        errors++;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || i_valid || expected_hits.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_epsilon(input logic [EPS_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        eps_model = v;
    endtask

    task automatic load_directed();
        t_box_pair p;
        logic [IN_W-1:0] id0, id1, id2;
        id0 = vec3(256, 0, 0); id1 = vec3(0, 256, 0); id2 = vec3(0, 0, 256);
        p = '{id0, id1, id2, '0, '0, vec3(256, 256, 256),
              id0, id1, id2, vec3(512, 0, 0), '0, vec3(256, 256, 256)};
        pending_pairs.push_back(p);                 // exact touch on A0
        p.b_translation = vec3(513, 0, 0); pending_pairs.push_back(p);
        p.b_translation = vec3(0, -600, 0); pending_pairs.push_back(p);
        p.b_translation = vec3(0, 0, 700); pending_pairs.push_back(p);
        p.b_translation = vec3(100, 50, 0); pending_pairs.push_back(p);
        // negative half widths
        p.a_half_width = vec3(-256, -256, -256); pending_pairs.push_back(p);
        // degenerate axes
        pending_pairs.push_back('{'0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0});
        // rotated B: 45 deg about z, favoring B and cross axes
        p = '{id0, id1, id2, '0, '0, vec3(256, 64, 256),
              vec3(181, 181, 0), vec3(-181, 181, 0), id2, vec3(300, 300, 0), '0,
              vec3(256, 32, 256)};
        pending_pairs.push_back(p);
        p.b_axis2 = vec3(0, 181, 181); p.b_translation = vec3(400, 0, 300);
        pending_pairs.push_back(p);
        // field extremes
        pending_pairs.push_back({12{48'hFFFF_FFFF_FFFF}});
        pending_pairs.push_back({12{48'h8000_8000_8000}});
        pending_pairs.push_back({12{48'h7FFF_7FFF_7FFF}});
        pending_pairs.push_back({12{48'h7FFF_8000_0001}});
        pending_pairs.push_back({12{48'h5555_AAAA_5555}});
        pending_pairs.push_back({12{48'hAAAA_5555_AAAA}});
        for (int k = 0; k < 8; k++) pending_pairs.push_back(plausible_pair());
    endtask

    initial begin
        logic [EPS_W-1:0] eps_set[5];
        eps_set = '{8'd0, 8'd255, 8'd1, 8'd17, 8'd128};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        load_directed();
        wait_drained();
        for (int ph = 0; ph < 5; ph++) begin
            write_epsilon(eps_set[ph]);
            for (int k = 0; k < 205; k++)
                pending_pairs.push_back($urandom_range(9) < 8 ? plausible_pair() : noise_pair());
            // idle phases: none, sender, receiver, both
            for (int q = 0; q < 4; q++) begin
                send_idle_pct  = (q == 1) ? 60 : (q == 3) ? 23 : 0;
                recv_stall_pct = (q == 2) ? 60 : (q == 3) ? 23 : 0;
                while (pending_pairs.size() > 205 - 51 * (q + 1) && pending_pairs.size() > 0)
                    @(posedge i_clk);
            end
            send_idle_pct = 0;
            recv_stall_pct = 0;
            wait_drained();
        end
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
